// ===== sv/ctc_pkg.sv =====
// Shared types and constants for the columnar transposition cipher unit.
package ctc_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int ROW_WIDTH_W      = 7;

  localparam logic [7:0]             PAD_CHAR      = 8'd32;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] text_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       none_left;
    logic       too_long;
  } out_word_t;

endpackage

// ===== sv/ctc_mem.sv =====
// Message store: one write port, one read port with registered read data.
module ctc_mem #(
  parameter int BUFFER_DEPTH = ctc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  // Write a message byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ctc_ctrl.sv =====
// Load, padding count, column-major address walk and output register.
module ctc_ctrl #(
  parameter int BUFFER_DEPTH = ctc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH),
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1),
  parameter int PAD_W        = $clog2(BUFFER_DEPTH + 128)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ctc_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ctc_pkg::out_word_t                  out_word,
  input  logic                                cfg_wr_en,
  input  logic [ctc_pkg::ROW_WIDTH_W-1:0]     cfg_wr_data,
  output logic                                mem_wr_en,
  output logic [AW-1:0]                       mem_wr_addr,
  output logic [7:0]                          mem_wr_data,
  output logic [AW-1:0]                       mem_rd_addr,
  input  logic [7:0]                          mem_rd_data
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_DAT  = 2'd3;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
  localparam logic [PAD_W-1:0] DEPTH_PAD = PAD_W'(BUFFER_DEPTH);

  logic [1:0]                        state_r, state_nxt;
  logic                              flag_r, flag_nxt;
  logic                              flag_none_r, flag_none_nxt;
  logic [ctc_pkg::ROW_WIDTH_W-1:0]   row_width_r;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              mode_r, mode_nxt;
  logic [PAD_W-1:0]                  pad_r, pad_nxt;
  logic [PAD_W-1:0]                  rows_r, rows_nxt;
  logic [PAD_W-1:0]                  ncols_r, ncols_nxt;
  logic [PAD_W-1:0]                  nrows_r, nrows_nxt;
  logic [PAD_W-1:0]                  k_r, k_nxt;
  logic [PAD_W-1:0]                  j_r, j_nxt;
  logic [PAD_W-1:0]                  addr_r, addr_nxt;
  logic [PAD_W-1:0]                  e_r, e_nxt;
  logic [PAD_W-1:0]                  end_r, end_nxt;
  logic                              scan_r, scan_nxt;
  logic                              found_r, found_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ctc_pkg::out_word_t                out_word_r, out_word_nxt;

  logic                              accept;
  logic                              store_ok;
  logic [PAD_W-1:0]                  w_ext;
  logic [PAD_W-1:0]                  len_ext;
  logic [7:0]                        cur_byte;
  logic                              out_free;
  logic                              col_end;
  logic                              walk_end;
  logic                              is_last;

  // Zero row width acts as one
  assign w_ext   = (row_width_r == '0) ? PAD_W'(1) : PAD_W'(row_width_r);
  assign len_ext = PAD_W'(cnt_r);

  assign in_stall = (state_r != S_LOAD) || flag_r;
  assign accept   = in_valid && !in_stall;
  assign store_ok = (cnt_r < DEPTH_CNT);

  assign mem_wr_en   = accept && store_ok;
  assign mem_wr_addr = cnt_r[AW-1:0];
  assign mem_wr_data = in_word.text_byte;
  assign mem_rd_addr = addr_r[AW-1:0];

  // Padding positions read as spaces
  assign cur_byte = (addr_r >= len_ext) ? ctc_pkg::PAD_CHAR : mem_rd_data;
  assign out_free = !out_valid_r || !out_stall;
  assign col_end  = (j_r + PAD_W'(1) == nrows_r);
  assign walk_end = col_end && (k_r + PAD_W'(1) == ncols_r);
  assign is_last  = (e_r == end_r);

  always_comb begin
    state_nxt     = state_r;
    flag_nxt      = flag_r;
    flag_none_nxt = flag_none_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    pad_nxt       = pad_r;
    rows_nxt      = rows_r;
    ncols_nxt     = ncols_r;
    nrows_nxt     = nrows_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    addr_nxt      = addr_r;
    e_nxt         = e_r;
    end_nxt       = end_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (flag_r) begin
      // Present a single flag word and close the message
      if (out_free) begin
        out_valid_nxt          = 1'b1;
        out_word_nxt.out_byte  = '0;
        out_word_nxt.out_last  = 1'b1;
        out_word_nxt.none_left = flag_none_r;
        out_word_nxt.too_long  = !flag_none_r;
        flag_nxt               = 1'b0;
        cnt_nxt                = '0;
        state_nxt              = S_LOAD;
      end
    end else begin
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (cnt_r == '0) begin
              mode_nxt = in_word.mode;
            end
            if (store_ok) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            if (in_word.last_byte) begin
              pad_nxt  = '0;
              rows_nxt = '0;
              if (!store_ok) begin
                flag_nxt      = 1'b1;
                flag_none_nxt = 1'b0;
              end else begin
                state_nxt = S_PAD;
              end
            end
          end
        end

        S_PAD: begin
          // Round the length up one row at a time
          if (pad_r < len_ext) begin
            pad_nxt  = pad_r + w_ext;
            rows_nxt = rows_r + PAD_W'(1);
          end else if (pad_r > DEPTH_PAD) begin
            flag_nxt      = 1'b1;
            flag_none_nxt = 1'b0;
          end else begin
            if (mode_r) begin
              ncols_nxt = rows_r;
              nrows_nxt = w_ext;
            end else begin
              ncols_nxt = w_ext;
              nrows_nxt = rows_r;
            end
            k_nxt     = '0;
            j_nxt     = '0;
            addr_nxt  = '0;
            e_nxt     = '0;
            end_nxt   = pad_r - PAD_W'(1);
            scan_nxt  = mode_r;
            found_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end

        S_RD: begin
          state_nxt = S_DAT;
        end

        S_DAT: begin
          if (scan_r) begin
            // Decrypt prescan: find the last non-space position
            if (cur_byte != ctc_pkg::PAD_CHAR) begin
              end_nxt   = e_r;
              found_nxt = 1'b1;
            end
            if (walk_end) begin
              if (!found_nxt) begin
                flag_nxt      = 1'b1;
                flag_none_nxt = 1'b1;
              end else begin
                k_nxt     = '0;
                j_nxt     = '0;
                addr_nxt  = '0;
                e_nxt     = '0;
                scan_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end else begin
              state_nxt = S_RD;
            end
          end else if (out_free) begin
            out_valid_nxt          = 1'b1;
            out_word_nxt.out_byte  = cur_byte;
            out_word_nxt.out_last  = is_last;
            out_word_nxt.none_left = 1'b0;
            out_word_nxt.too_long  = 1'b0;
            if (is_last) begin
              cnt_nxt   = '0;
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_RD;
            end
          end

          // Advance the walk down a column, then to the next column
          if (scan_r ? !walk_end : (out_free && !is_last)) begin
            e_nxt = e_r + PAD_W'(1);
            if (col_end) begin
              j_nxt    = '0;
              k_nxt    = k_r + PAD_W'(1);
              addr_nxt = k_r + PAD_W'(1);
            end else begin
              j_nxt    = j_r + PAD_W'(1);
              addr_nxt = addr_r + ncols_r;
            end
          end
        end

        default: begin
          state_nxt = S_LOAD;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      flag_r      <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      row_width_r <= ctc_pkg::ROW_WIDTH_RST;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        row_width_r <= cfg_wr_data;
      end
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    flag_none_r <= flag_none_nxt;
    pad_r       <= pad_nxt;
    rows_r      <= rows_nxt;
    ncols_r     <= ncols_nxt;
    nrows_r     <= nrows_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    addr_r      <= addr_nxt;
    e_r         <= e_nxt;
    end_r       <= end_nxt;
    scan_r      <= scan_nxt;
    found_r     <= found_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/columnar_transposition_cipher_unit.sv =====
// Top level of the columnar transposition cipher unit.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall    ctc_pkg::in_word_t
//   out_     output     out_valid / out_stall  ctc_pkg::out_word_t
//   cfg_     input      cfg_wr_en              cfg_wr_data (row width)
//
// Loading takes one word per cycle. On the last byte the padded length is found
// by adding one row width per cycle, then checked against the store depth; then
// each result takes two steps: a store read, then a load of the output register.
// Decrypt first walks the whole padded block once (a store read and a check per
// position) to locate the last non-space. Flag results load the output directly.
// Reset (rst_n low at a clock edge) clears the control state and sets row width
// to 4; the store is not cleared. in_stall stays high from the last byte until
// the final result is loaded; with a result waiting, out_stall holds the output
// walk in place (the decrypt prescan does not wait for it).
module columnar_transposition_cipher_unit #(
  parameter int BUFFER_DEPTH = ctc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ctc_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ctc_pkg::out_word_t              out_word,
  input  logic                            cfg_wr_en,
  input  logic [ctc_pkg::ROW_WIDTH_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  // Message store
  ctc_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequencer and output register
  ctc_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule
